@@ hw/rtl/sitrt_pkg.sv @@
// Shared types, constants and the digit-to-ASCII function for the
// signed integer to radix text block. No dependencies.

package sitrt_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int NUMBER_W    = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int DIV_STEP    = 8;
    localparam int FIFO_AW     = 1;
    localparam int FIFO_DEPTH  = 1 << FIFO_AW;
    localparam int IDX_W       = $clog2(VALUE_BITS);
    localparam int BL_W        = $clog2(VALUE_BITS + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 7'h2D;
    localparam logic [CHAR_W-1:0]  ZERO_CHAR   = 7'h30;
    localparam logic [CHAR_W-1:0]  ALPHA_BASE  = 7'h57;

    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic                  neg;
        logic [RADIX_W-1:0]    radix;
    } work_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dz;
        dz = CHAR_W'(d);
        if (d < RADIX_W'(10))
            return ZERO_CHAR + dz;
        else
            return ALPHA_BASE + dz;
    endfunction

endpackage

@@ hw/rtl/sitrt_front.sv @@
// Front end: radix register, input acceptance, sign split and magnitude.
// Depends on sitrt_pkg.

module sitrt_front
    import sitrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [NUMBER_W-1:0] number,
    input  logic                radix_valid,
    output logic                radix_ready,
    input  logic [RADIX_W-1:0]  radix,
    input  logic                q_full,
    output logic                q_push,
    output work_t               q_data
);

    logic [RADIX_W-1:0]    radix_reg;
    logic [VALUE_BITS-1:0] raw;
    logic                  radix_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (radix_valid && radix_ready)
            radix_reg <= radix;
    end

    always_comb
    begin
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            if (i < NUMBER_W)
                raw[i] = number[i];
            else
                raw[i] = 1'b0;
        end
    end

    assign radix_ready = 1'b1;
    assign radix_ok    = (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX);
    assign in_stall    = q_full;

    // drop items under an unusable base: they produce no text
    assign q_push        = in_valid && !q_full && radix_ok;
    assign q_data.neg    = raw[VALUE_BITS-1];
    assign q_data.mag    = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
    assign q_data.radix  = radix_reg;

endmodule

@@ hw/rtl/sitrt_fifo.sv @@
// Short work queue between the front end and the conversion engine.
// Depends on sitrt_pkg.

module sitrt_fifo
    import sitrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output work_t pop_data
);

    work_t              slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (FIFO_AW+1)'(1);
        end
    end

endmodule

@@ hw/rtl/sitrt_back.sv @@
// Conversion engine: iterative divide by the radix, digit stack, and the
// registered character output. Depends on sitrt_pkg.

module sitrt_back
    import sitrt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  work_t             q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] character,
    output logic              final_char
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_FETCH, ST_EMIT} state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [RADIX_W-1:0]    rem_reg, rem_next;
    logic [BL_W-1:0]       bits_left_reg, bits_left_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic                  neg_reg, neg_next;
    logic [IDX_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  final_reg, final_next;

    logic [RADIX_W-1:0]    digit_mem [VALUE_BITS];
    logic [RADIX_W-1:0]    rdata_reg;
    logic                  mem_we;

    logic [VALUE_BITS-1:0] d;
    logic [RADIX_W-1:0]    r;
    logic [RADIX_W:0]      t;
    logic                  load_ok;

    // digit stack, written least significant first, read back in reverse
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[wr_ptr_reg] <= r;
        rdata_reg <= digit_mem[rd_ptr_next];
    end

    // up to DIV_STEP restoring-division bits per cycle, MSB first
    always_comb
    begin
        d = div_reg;
        r = rem_reg;
        t = '0;
        for (int j = 0; j < DIV_STEP; j++)
        begin
            if (BL_W'(j) < bits_left_reg)
            begin
                t = {r, d[VALUE_BITS-1]};
                d = {d[VALUE_BITS-2:0], 1'b0};
                if (t >= {1'b0, radix_reg})
                begin
                    t    = t - {1'b0, radix_reg};
                    d[0] = 1'b1;
                end
                r = t[RADIX_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        bits_left_next = bits_left_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        final_next     = final_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;

        load_ok = !out_valid_reg || !out_stall;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    div_next       = q_data.mag;
                    rem_next       = '0;
                    bits_left_next = BL_W'(VALUE_BITS);
                    radix_next     = q_data.radix;
                    neg_next       = q_data.neg;
                    wr_ptr_next    = '0;
                    state_next     = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (bits_left_reg <= BL_W'(DIV_STEP))
                begin
                    mem_we = 1'b1;
                    if (d == '0)
                    begin
                        rd_ptr_next = wr_ptr_reg;
                        state_next  = ST_FETCH;
                    end
                    else
                    begin
                        div_next       = d;
                        rem_next       = '0;
                        bits_left_next = BL_W'(VALUE_BITS);
                        wr_ptr_next    = wr_ptr_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    div_next       = d;
                    rem_next       = r;
                    bits_left_next = bits_left_reg - BL_W'(DIV_STEP);
                end
            end
            ST_FETCH:
            begin
                // hold the read address so the top digit lands in rdata_reg
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        char_next  = MINUS_CHAR;
                        final_next = 1'b0;
                        neg_next   = 1'b0;
                    end
                    else
                    begin
                        char_next  = digit_char(rdata_reg);
                        final_next = (rd_ptr_reg == '0);
                        if (rd_ptr_reg == '0)
                            state_next = ST_IDLE;
                        else
                            rd_ptr_next = rd_ptr_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            bits_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            bits_left_reg <= bits_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        char_reg  <= char_next;
        final_reg <= final_next;
    end

    assign out_valid  = out_valid_reg;
    assign character  = char_reg;
    assign final_char = final_reg;

endmodule

@@ hw/rtl/signed_integer_to_radix_text.sv @@
// An accepted number leaves the queue, the 8-bit-per-cycle divider
// produces its digits, the top digit is fetched from the stack, and the
// output register is loaded with a minus sign, if any, then each digit.
// No new number starts until the last character is loaded; characters of
// a number leave at one per cycle while the output is not stalled.
// Reset: the base returns to ten, queue and engine empty; no stack clearing.

module signed_integer_to_radix_text
    import sitrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [NUMBER_W-1:0] number,
    input  logic                radix_valid,
    output logic                radix_ready,
    input  logic [RADIX_W-1:0]  radix,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CHAR_W-1:0]   character,
    output logic                final_char
);

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    work_t q_in;
    work_t q_out;

    sitrt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .number      (number),
        .radix_valid (radix_valid),
        .radix_ready (radix_ready),
        .radix       (radix),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    sitrt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    sitrt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .character  (character),
        .final_char (final_char)
    );

endmodule

@@ hw/rtl/sitrt_checker.sv @@
// Port-level checks for the radix text block, bound to the top level.
// Depends on sitrt_pkg.

module sitrt_checker
    import sitrt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [CHAR_W-1:0]   character,
    input logic                final_char
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(character) && $stable(final_char))
        else $error("output payload changed while stalled");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == MINUS_CHAR)
                   || (character >= 7'h30 && character <= 7'h39)
                   || (character >= 7'h61 && character <= 7'h7A))
        else $error("character outside the digit and sign set");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && character == MINUS_CHAR |-> !final_char)
        else $error("minus sign flagged as last character");

    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && character == MINUS_CHAR ##1 out_valid
        |-> character != MINUS_CHAR)
        else $error("minus sign repeated");

endmodule

bind signed_integer_to_radix_text sitrt_checker u_sitrt_checker (.*);

@@ tb/sv/tb_signed_integer_to_radix_text.sv @@
// Testbench for signed_integer_to_radix_text: converts numbers in several bases,
// predicts each character of their text and checks every output transaction.
// Depends on sitrt_pkg and the signed_integer_to_radix_text RTL only.
`timescale 1ns / 1ps

module tb_signed_integer_to_radix_text;
    import sitrt_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          IDLE_PERCENT  = 37;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // Predicted text of every accepted number, oldest character first.
    class radix_text_book;
        logic [RADIX_W-1:0] base;
        text_char_t         expected_chars[$];
        int unsigned        mismatches;

        function new();
            base       = RADIX_RESET;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction

        function void complain(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $time, what);
        endfunction

        // Divide the magnitude down; the first digit found is the last one sent.
        function void note_number(logic [NUMBER_W-1:0] value);
            string               digit_text;
            logic [NUMBER_W-1:0] magnitude;
            logic [NUMBER_W-1:0] place;
            text_char_t          text[$];
            text_char_t          one;
            digit_text = "0123456789abcdefghijklmnopqrstuvwxyz";
            if (base < RADIX_MIN || base > RADIX_MAX)
                return;
            magnitude = value[NUMBER_W-1] ? -value : value;
            do
            begin
                place     = magnitude % base;
                magnitude = magnitude / base;
                one.code  = CHAR_W'(digit_text[place]);
                one.last  = (text.size() == 0);
                text.push_front(one);
            end
            while (magnitude != 0);
            if (value[NUMBER_W-1])
            begin
                one.code = MINUS_CHAR;
                one.last = 1'b0;
                text.push_front(one);
            end
            foreach (text[k])
                expected_chars.push_back(text[k]);
        endfunction

        function void check_char(logic [CHAR_W-1:0] code, logic last);
            text_char_t want;
            if (expected_chars.size() == 0)
            begin
                complain($sformatf("unexpected character %h last %b", code, last));
                return;
            end
            want = expected_chars.pop_front();
            if (want.code !== code || want.last !== last)
                complain($sformatf("expected character %h last %b, got %h last %b",
                                   want.code, want.last, code, last));
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [NUMBER_W-1:0] number      = '0;
    logic                radix_valid = 1'b0;
    logic                radix_ready;
    logic [RADIX_W-1:0]  radix       = RADIX_RESET;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [CHAR_W-1:0]   character;
    logic                final_char;

    logic                hold_req    = 1'b0;
    bit                  gaps_on     = 1'b1;
    int unsigned         hold_left   = 0;
    int unsigned         cycle_count = 0;
    radix_text_book      book        = new();

    signed_integer_to_radix_text u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .number      (number),
        .radix_valid (radix_valid),
        .radix_ready (radix_ready),
        .radix       (radix),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .final_char  (final_char)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Output side: check each transaction, then decide the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                book.check_char(character, final_char);
            if (hold_req)
                hold_left = HOLD_CYCLES;
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= gaps_on && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    task automatic send_number(input logic [NUMBER_W-1:0] value);
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_number(value);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] value);
        radix_valid <= 1'b1;
        radix       <= value;
        @(posedge clk);
        while (!radix_ready)
            @(posedge clk);
        radix_valid <= 1'b0;
        book.base = value;
    endtask

    // Drop valid, drain every predicted character, then let the engine settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        logic [RADIX_W-1:0]  dir_radix [3] = '{6'd10, 6'd2, 6'd36};
        logic [RADIX_W-1:0]  bad_radix [4] = '{6'd0, 6'd1, 6'd37, 6'd63};
        logic [NUMBER_W-1:0] bad_value [4] = '{32'd123, 32'hffff_fff9, 32'd0,
                                               32'h8000_0000};
        logic [NUMBER_W-1:0] pick;
        logic [RADIX_W-1:0]  base_pick;
        int                  count;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes and digit boundaries in the smallest, decimal and largest bases.
        foreach (dir_radix[k])
        begin
            wait_idle();
            write_radix(dir_radix[k]);
            send_number('0);
            send_number(32'h0000_0001);
            send_number(32'h7fff_ffff);
            send_number(32'h8000_0000);
            send_number(NUMBER_W'(dir_radix[k] - 1));
            send_number(NUMBER_W'(dir_radix[k]));
            send_number(-NUMBER_W'(dir_radix[k] - 1));
        end

        // Bases the converter rejects: no text at all.
        foreach (bad_radix[k])
        begin
            wait_idle();
            write_radix(bad_radix[k]);
            send_number(bad_value[k]);
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            case (phase)
                1: base_pick = RADIX_MIN;
                2: base_pick = $urandom_range(1) ? RADIX_W'($urandom_range(37, 63))
                                                 : RADIX_W'($urandom_range(0, 1));
                3: base_pick = RADIX_MAX;
                default: base_pick = RADIX_W'($urandom_range(2, 36));
            endcase
            write_radix(base_pick);
            gaps_on = (phase != 4);
            count   = (phase == 2) ? 6 : 27;
            if (phase == 5)
            begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            for (int i = 0; i < count; i++)
            begin
                case ($urandom_range(4))
                    0, 1: pick = $urandom;
                    2: begin
                        pick = $urandom_range(0, 400);
                        if ($urandom_range(1))
                            pick = -pick;
                    end
                    3: begin
                        pick = $urandom >> $urandom_range(1, 31);
                        if ($urandom_range(1))
                            pick = -pick;
                    end
                    default: pick = $urandom_range(1)
                                  ? 32'h8000_0000 + $urandom_range(0, 2)
                                  : 32'h7fff_ffff - $urandom_range(0, 2);
                endcase
                send_number(pick);
            end
        end
        gaps_on = 1'b1;

        wait_idle();
        if (book.mismatches == 0 && book.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sitrt_pkg.sv
hw/rtl/sitrt_front.sv
hw/rtl/sitrt_fifo.sv
hw/rtl/sitrt_back.sv
hw/rtl/signed_integer_to_radix_text.sv
hw/rtl/sitrt_checker.sv
tb/sv/tb_signed_integer_to_radix_text.sv
